// ----- rtl/mpt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix point transform package
// Shared word type, mode and status codes and datapath widths.
// ---------------------------------------------------------------------------
package mpt_pkg;

    typedef logic signed [31:0] t_word;

    localparam int MPT_FRAC_BITS = 16;
    // Accumulator width: three 32x33 products summed, plus headroom.
    localparam int ACC_W = 68;
    localparam int Q_W = 32;

    localparam logic [2:0] MODE_LOAD       = 3'd0;
    localparam logic [2:0] MODE_AFFINE     = 3'd1;
    localparam logic [2:0] MODE_INV_AFFINE = 3'd2;
    localparam logic [2:0] MODE_ROTATE     = 3'd3;
    localparam logic [2:0] MODE_INV_ROTATE = 3'd4;
    localparam logic [2:0] MODE_PROJ       = 3'd5;
    localparam logic [2:0] MODE_POST_TRANS = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

endpackage

// ----- rtl/mpt_lane.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dot product lane
// Three multiply-accumulate steps through one multiplier, then one
// round-half-up to the output fraction width and the added offset.
// ---------------------------------------------------------------------------
module mpt_lane
    import mpt_pkg::*;
#(
    parameter int FRAC_BITS = MPT_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  t_word                              i_a [3],
    input  logic signed [32:0]                 i_t [3],
    input  t_word                              i_add,
    output logic                               o_done,
    output logic signed [ACC_W-FRAC_BITS:0]    o_dot
);

    localparam int DOT_W = ACC_W - FRAC_BITS + 1;

    t_word                     r_a [3];
    logic signed [32:0]        r_t [3];
    t_word                     r_add;
    logic signed [64:0]        r_prod;
    logic                      r_pv;
    logic signed [ACC_W-1:0]   r_acc;
    logic [2:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic signed [DOT_W-1:0]   r_dot;
    logic [ACC_W-1:0]          w_rnd;
    logic signed [DOT_W-1:0]   w_dot;

    assign w_rnd = r_acc + {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    assign w_dot = DOT_W'(signed'(w_rnd[ACC_W-1:FRAC_BITS])) + DOT_W'(r_add);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_pv   <= 1'b0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_t    <= i_t;
                r_add  <= i_add;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt < 3'd3) begin
                    r_prod <= r_a[0] * r_t[0];
                    r_a[0] <= r_a[1];
                    r_a[1] <= r_a[2];
                    r_t[0] <= r_t[1];
                    r_t[1] <= r_t[2];
                    r_pv   <= 1'b1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_dot  <= w_dot;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_dot  = r_dot;

endmodule

// ----- rtl/mpt_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Projective divider
// Restoring division, one quotient bit per cycle, of num * 2^FRAC_BITS by
// den, truncated toward zero and saturated to 32 bits.
// ---------------------------------------------------------------------------
module mpt_div
    import mpt_pkg::*;
#(
    parameter int FRAC_BITS = MPT_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ACC_W-FRAC_BITS:0]    i_num,
    input  logic signed [ACC_W-FRAC_BITS:0]    i_den,
    output logic                               o_done,
    output t_word                              o_q,
    output logic                               o_sat
);

    localparam int DOT_W = ACC_W - FRAC_BITS + 1;
    localparam int NW    = DOT_W + FRAC_BITS;
    localparam int RW    = DOT_W + 1;

    logic [DOT_W-1:0]  w_un;
    logic [DOT_W-1:0]  w_ud;
    logic [NW-1:0]     w_n;
    logic [NW-1:0]     w_rn;
    logic [RW-1:0]     w_hi;
    logic [RW-1:0]     w_rem2;
    logic [DOT_W-1:0]  r_un;
    logic [DOT_W-1:0]  r_ud;
    logic [RW-1:0]     r_rem;
    logic [Q_W-1:0]    r_lo;
    logic [Q_W-1:0]    r_q;
    logic              r_neg;
    logic              r_ovf;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    assign w_un   = i_num[DOT_W-1] ? DOT_W'(~i_num + 1'b1) : DOT_W'(i_num);
    assign w_ud   = i_den[DOT_W-1] ? DOT_W'(~i_den + 1'b1) : DOT_W'(i_den);
    assign w_n    = {w_un, {FRAC_BITS{1'b0}}};
    assign w_rn   = {r_un, {FRAC_BITS{1'b0}}};
    assign w_hi   = RW'(w_rn[NW-1:Q_W]);
    assign w_rem2 = {r_rem[RW-2:0], r_lo[Q_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_un   <= w_un;
                r_ud   <= w_ud;
                r_lo   <= w_n[Q_W-1:0];
                r_neg  <= i_num[DOT_W-1] ^ i_den[DOT_W-1];
                r_ovf  <= 1'b0;
                r_q    <= '0;
            end else if (r_busy) begin
                if (r_cnt == 6'd33) begin
                    // Quotient of 2^32 or more cannot be represented.
                    if (w_hi >= RW'(r_ud)) begin
                        r_ovf  <= 1'b1;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_rem <= w_hi;
                        r_cnt <= 6'd32;
                    end
                end else begin
                    r_lo  <= {r_lo[Q_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (w_rem2 >= RW'(r_ud)) begin
                        r_rem <= w_rem2 - RW'(r_ud);
                        r_q   <= {r_q[Q_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_q   <= {r_q[Q_W-2:0], 1'b0};
                    end
                    if (r_cnt == 6'd1) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_sat  = r_ovf || (!r_neg && r_q[Q_W-1]) || (r_neg && (r_q > Q_MIN));
    assign o_q    = o_sat ? (r_neg ? Q_MIN : Q_MAX) : (r_neg ? (~r_q + 1'b1) : r_q);
    assign o_done = r_done;

endmodule

// ----- rtl/matrix_point_transform.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix point transform
// 4x4 Q-format matrix store with affine, rotation and projective transforms.
// ---------------------------------------------------------------------------
// The input channel (i_valid / o_ready) takes one command per transfer: a
// matrix entry load, a post-translate, or a point transform of the vector.
// The output channel (o_valid / i_ready) returns exactly one result per
// command, in order, from an output register, so a finished result can wait
// for the receiver while the block returns to idle and takes the next
// command. A stalled receiver only holds the output register; the block then
// finishes at most one more command and waits with it until the register
// frees up.
// Loads, post-translates and the unused mode go from the transfer straight
// to the output state and then into the output register. Affine, inverse and
// rotate commands pass through four dot product lanes, each doing three
// multiply-accumulate steps and rounding through one multiplier; the merge
// stage then registers the results ahead of the output register. Projective
// commands also run the shared bit-serial divider, which handles the three
// numerators in turn. The block works on one command at a time and takes the
// next one only once it is back in idle.
// Reset loads the identity matrix and empties the output register.
// ---------------------------------------------------------------------------
module matrix_point_transform
    import mpt_pkg::*;
#(
    parameter int FRAC_BITS = MPT_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_mode,
    input  logic [1:0]        i_row,
    input  logic [1:0]        i_col,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [31:0] o_res_x,
    output logic signed [31:0] o_res_y,
    output logic signed [31:0] o_res_z,
    output logic [1:0]        o_status
);

    localparam int DOT_W = ACC_W - FRAC_BITS + 1;
    localparam t_word L_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [DOT_W-1:0] L_MAX = DOT_W'(32'sh7FFF_FFFF);
    localparam logic signed [DOT_W-1:0] L_MIN =
        signed'({{(DOT_W-32){1'b1}}, 1'b1, 31'b0});

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    t_word                    r_mat [4][4];
    logic [2:0]               r_mode;
    t_word                    r_res [3];
    logic [1:0]               r_stat;
    logic [1:0]               r_idx;
    logic                     r_flag;
    logic                     r_div_start;
    logic                     r_o_valid;
    t_word                    r_ox;
    t_word                    r_oy;
    t_word                    r_oz;
    logic [1:0]               r_ostat;

    logic                     w_accept;
    logic                     w_lane_start;
    logic                     w_trans;
    logic                     w_addsel;
    t_word                    w_v [3];
    logic signed [32:0]       w_t [3];
    t_word                    w_a [4][3];
    t_word                    w_add [4];
    logic [3:0]               w_done;
    logic signed [DOT_W-1:0]  w_dot [4];
    logic [32:0]              w_sat [3];
    logic signed [32:0]       w_pt [3];
    logic                     w_pt_ovf [3];
    logic                     w_div_done;
    t_word                    w_div_q;
    logic                     w_div_sat;
    logic                     w_flag;
    logic                     w_out_free;

    // Saturate a rounded dot product to 32 bits; bit 32 is the flag.
    function automatic logic [32:0] f_sat(input logic signed [DOT_W-1:0] x);
        logic [32:0] res;
        if (x > L_MAX) begin
            res = {1'b1, Q_MAX};
        end else if (x < L_MIN) begin
            res = {1'b1, Q_MIN};
        end else begin
            res = {1'b0, x[31:0]};
        end
        return res;
    endfunction

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_v[0] = i_vec_x;
    assign w_v[1] = i_vec_y;
    assign w_v[2] = i_vec_z;

    always_comb begin
        w_lane_start = 1'b0;
        case (i_mode) inside
            MODE_AFFINE, MODE_INV_AFFINE, MODE_ROTATE, MODE_INV_ROTATE, MODE_PROJ: begin
                w_lane_start = w_accept;
            end
            default: begin
                w_lane_start = 1'b0;
            end
        endcase
    end

    assign w_trans  = (i_mode == MODE_INV_AFFINE) || (i_mode == MODE_INV_ROTATE);
    assign w_addsel = (i_mode == MODE_AFFINE) || (i_mode == MODE_PROJ);

    // Lane operands: the three output rows (or columns when transposed) and
    // the fourth row as the projective divisor.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_t[j] = (i_mode == MODE_INV_AFFINE) ? (33'(w_v[j]) - 33'(r_mat[j][3]))
                                                 : 33'(w_v[j]);
            w_pt[j] = 33'(r_mat[j][3]) + 33'(w_v[j]);
            w_pt_ovf[j] = w_pt[j][32] != w_pt[j][31];
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_a[i][j] = w_trans ? r_mat[j][i] : r_mat[i][j];
            end
            w_add[i] = w_addsel ? r_mat[i][3] : '0;
        end
        for (int j = 0; j < 3; j++) begin
            w_a[3][j] = r_mat[3][j];
        end
        w_add[3] = r_mat[3][3];
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        mpt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_lane_start),
            .i_a     (w_a[g]),
            .i_t     (w_t),
            .i_add   (w_add[g]),
            .o_done  (w_done[g]),
            .o_dot   (w_dot[g])
        );
    end

    // Merge stage: saturation of the three lanes, or the divider for
    // the projective case.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sat[i] = f_sat(w_dot[i]);
        end
    end

    mpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_dot[r_idx]),
        .i_den   (w_dot[3]),
        .o_done  (w_div_done),
        .o_q     (w_div_q),
        .o_sat   (w_div_sat)
    );

    assign w_flag = r_flag || w_div_sat;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_lane_start ? S_CALC : S_OUT;
                end
            end
            S_CALC: begin
                if (w_done[0]) begin
                    n_state = ((r_mode == MODE_PROJ) && (w_dot[3] != '0)) ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                if (w_div_done && (r_idx == 2'd2)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_div_start <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_mat[i][j] <= (i == j) ? L_ONE : '0;
                end
            end
        end else begin
            r_state     <= n_state;
            r_div_start <= 1'b0;

            if (w_accept) begin
                r_mode <= i_mode;
                r_idx  <= '0;
                r_flag <= 1'b0;
                r_stat <= ST_OK;
                for (int i = 0; i < 3; i++) begin
                    r_res[i] <= '0;
                end
                if (i_mode == MODE_LOAD) begin
                    r_mat[i_row][i_col] <= i_entry_value;
                end else if (i_mode == MODE_POST_TRANS) begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_pt_ovf[i]) begin
                            r_mat[i][3] <= w_pt[i][32] ? Q_MIN : Q_MAX;
                        end else begin
                            r_mat[i][3] <= w_pt[i][31:0];
                        end
                    end
                    r_stat <= (w_pt_ovf[0] || w_pt_ovf[1] || w_pt_ovf[2]) ? ST_SAT : ST_OK;
                end
            end

            if ((r_state == S_CALC) && w_done[0]) begin
                if (r_mode == MODE_PROJ) begin
                    if (w_dot[3] == '0) begin
                        r_stat <= ST_DIV0;
                    end else begin
                        r_div_start <= 1'b1;
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_res[i] <= w_sat[i][31:0];
                    end
                    r_stat <= (w_sat[0][32] || w_sat[1][32] || w_sat[2][32]) ? ST_SAT : ST_OK;
                end
            end

            if ((r_state == S_DIV) && w_div_done) begin
                r_res[r_idx] <= w_div_q;
                r_flag       <= w_flag;
                if (r_idx == 2'd2) begin
                    r_stat <= w_flag ? ST_SAT : ST_OK;
                end else begin
                    r_idx       <= r_idx + 2'd1;
                    r_div_start <= 1'b1;
                end
            end

            if ((r_state == S_OUT) && w_out_free) begin
                r_o_valid <= 1'b1;
                r_ox      <= r_res[0];
                r_oy      <= r_res[1];
                r_oz      <= r_res[2];
                r_ostat   <= r_stat;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_res_x  = r_ox;
    assign o_res_y  = r_oy;
    assign o_res_z  = r_oz;
    assign o_status = r_ostat;

`ifndef SYNTHESIS
    // The four lanes start together and must finish together.
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done == 4'b0000) || (w_done == 4'b1111))
        else $error("dot product lanes out of step");

    // Only projective commands use the divider.
    a_div_proj_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_mode == MODE_PROJ))
        else $error("divider running for a non-projective command");

    // A projective transfer starts the lanes.
    a_proj_starts_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_mode == MODE_PROJ)) |=> (r_state == S_CALC))
        else $error("projective command did not start the lanes");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix point transform testbench
// Drives matrix loads, post-translates and every transform mode, predicts
// each result from a local copy of the matrix and checks results in order.
// ---------------------------------------------------------------------------
module testbench;
    import mpt_pkg::*;

    localparam int FB = MPT_FRAC_BITS;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         status;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [2:0]        i_mode;
    logic [1:0]        i_row;
    logic [1:0]        i_col;
    logic signed [31:0] i_entry_value;
    logic signed [31:0] i_vec_x;
    logic signed [31:0] i_vec_y;
    logic signed [31:0] i_vec_z;
    logic              o_valid;
    logic              i_ready;
    logic signed [31:0] o_res_x;
    logic signed [31:0] o_res_y;
    logic signed [31:0] o_res_z;
    logic [1:0]        o_status;

    // Local copy of the matrix, index row*4+col.
    logic signed [31:0] mat_copy [16];
    t_result            pending_results [$];
    int                 error_count;
    int                 items_sent;
    int                 results_seen;
    longint             cycle_count;

    matrix_point_transform i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The cycle counter ends a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint entry_of(int r, int c);
        return longint'(mat_copy[r * 4 + c]);
    endfunction

    // Floor division by 2^FB keeps the remainder non-negative; the three
    // remainders are summed with the half-LSB constant and rounded once.
    function automatic longint round_dot(longint a [3], longint b [3], longint add);
        longint q_sum;
        longint r_sum;
        longint p;
        longint q;
        q_sum = 0;
        r_sum = 0;
        for (int k = 0; k < 3; k++) begin
            p = a[k] * b[k];
            q = p >>> FB;
            q_sum += q;
            r_sum += p - (q <<< FB);
        end
        r_sum += longint'(1) <<< (FB - 1);
        return q_sum + add + (r_sum >>> FB);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Numerator * 2^FB / divisor, truncated toward zero, then clamped.
    function automatic logic signed [31:0] proj_quotient(longint n, longint d,
                                                         ref logic flag);
        logic              neg;
        logic [127:0]      un;
        logic [127:0]      ud;
        logic [127:0]      mag;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? 128'(-n) : 128'(n);
        ud = (d < 0) ? 128'(-d) : 128'(d);
        mag = (un << FB) / ud;
        if (!neg && mag > 128'h7FFF_FFFF) begin
            flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (neg && mag > 128'h8000_0000) begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return neg ? -mag[31:0] : mag[31:0];
    endfunction

    // Predicts the result of one command and updates the matrix copy.
    function automatic t_result predict_transform(logic [2:0] mode, logic [1:0] row,
                                                  logic [1:0] col,
                                                  logic signed [31:0] value,
                                                  logic signed [31:0] vx,
                                                  logic signed [31:0] vy,
                                                  logic signed [31:0] vz);
        t_result            res;
        longint             v [3];
        longint             a [3];
        longint             t [3];
        longint             d;
        logic               flag;
        logic signed [31:0] o [3];
        logic               transpose;
        flag = 1'b0;
        o[0] = '0;
        o[1] = '0;
        o[2] = '0;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        res.status = ST_OK;
        case (mode)
            MODE_LOAD: begin
                mat_copy[{row, col}] = value;
            end
            MODE_POST_TRANS: begin
                for (int i = 0; i < 3; i++)
                    mat_copy[i * 4 + 3] = clamp32(entry_of(i, 3) + v[i], flag);
                res.status = flag ? ST_SAT : ST_OK;
            end
            MODE_PROJ: begin
                for (int j = 0; j < 3; j++) a[j] = entry_of(3, j);
                d = round_dot(a, v, entry_of(3, 3));
                if (d == 0) begin
                    res.status = ST_DIV0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3; j++) a[j] = entry_of(i, j);
                        o[i] = proj_quotient(round_dot(a, v, entry_of(i, 3)), d, flag);
                    end
                    res.status = flag ? ST_SAT : ST_OK;
                end
            end
            MODE_AFFINE, MODE_INV_AFFINE, MODE_ROTATE, MODE_INV_ROTATE: begin
                transpose = (mode == MODE_INV_AFFINE) || (mode == MODE_INV_ROTATE);
                for (int j = 0; j < 3; j++)
                    t[j] = (mode == MODE_INV_AFFINE) ? v[j] - entry_of(j, 3) : v[j];
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++)
                        a[j] = transpose ? entry_of(j, i) : entry_of(i, j);
                    o[i] = clamp32(round_dot(a, t, (mode == MODE_AFFINE) ?
                                             entry_of(i, 3) : 0), flag);
                end
                res.status = flag ? ST_SAT : ST_OK;
            end
            default: begin
            end
        endcase
        res.x = o[0];
        res.y = o[1];
        res.z = o[2];
        return res;
    endfunction

    // Sends one command: random gap, then holds valid until the transfer.
    // Valid drops only when a gap follows, so back-to-back commands keep it high.
    task automatic send_command(logic [2:0] mode, logic [1:0] row, logic [1:0] col,
                                logic signed [31:0] value, logic signed [31:0] vx,
                                logic signed [31:0] vy, logic signed [31:0] vz);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_row         <= row;
        i_col         <= col;
        i_entry_value <= value;
        i_vec_x       <= vx;
        i_vec_y       <= vy;
        i_vec_z       <= vz;
        do @(posedge i_clk); while (!o_ready);
        // The expectation is queued at the edge of the transfer itself.
        pending_results.push_back(predict_transform(mode, row, col, value, vx, vy, vz));
        items_sent++;
    endtask

    // The receiver stalls a random number of cycles per result.
    initial begin
        int stall;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) i_ready <= 1'b0;
            else if (!i_ready) begin
                stall = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0) stall = 0;
                repeat (stall) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    // Checks every result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transfer with no command outstanding");
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_res_x !== exp_res.x) begin
                    $error("res_x expected %0d actual %0d", exp_res.x, o_res_x);
                    error_count++;
                end
                if (o_res_y !== exp_res.y) begin
                    $error("res_y expected %0d actual %0d", exp_res.y, o_res_y);
                    error_count++;
                end
                if (o_res_z !== exp_res.z) begin
                    $error("res_z expected %0d actual %0d", exp_res.z, o_res_z);
                    error_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status expected %0d actual %0d", exp_res.status, o_status);
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(0, 1 << 18))) - (1 <<< 17);
            default: return $urandom;
        endcase
    endfunction

    // Moderate Q16.16 values keep most transforms out of saturation.
    function automatic logic signed [31:0] rand_coord();
        return $signed(32'($urandom_range(0, 1 << 22))) - (1 <<< 21);
    endfunction

    task automatic load_entry(int r, int c, logic signed [31:0] value);
        send_command(MODE_LOAD, 2'(r), 2'(c), value, rand_word(), rand_word(), rand_word());
    endtask

    // Identity matrix, each mode at the field extremes, plus a zero divisor.
    task automatic test_directed_modes();
        send_command(MODE_AFFINE, 2'd0, 2'd0, 0, 32'sh0001_0000, -32'sh0002_0000, 32'sd5);
        send_command(MODE_AFFINE, 2'd3, 2'd3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh7FFF_FFFF);
        send_command(MODE_INV_AFFINE, 2'd0, 2'd0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_command(MODE_ROTATE, 2'd1, 2'd2, -1, -1, 1, 32'sh0000_8000);
        send_command(MODE_INV_ROTATE, 2'd2, 2'd1, 0, 32'sh1234_5678, -32'sh10, 3);
        send_command(MODE_PROJ, 2'd0, 2'd0, 0, 32'sh0003_0000, 32'sh0004_0000, 7);
        send_command(MODE_POST_TRANS, 2'd0, 2'd0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -1);
        send_command(MODE_POST_TRANS, 2'd0, 2'd0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
        send_command(MODE_INV_AFFINE, 2'd0, 2'd0, 0, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_command(3'd7, 2'd3, 2'd3, 32'sh7FFF_FFFF, 1, 2, 3);
        load_entry(0, 0, 32'sh7FFF_FFFF);
        load_entry(1, 1, 32'sh8000_0000);
        load_entry(3, 3, 0);
        send_command(MODE_AFFINE, 2'd0, 2'd0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
        // Bottom row now zero: the projective divisor is zero.
        send_command(MODE_PROJ, 2'd0, 2'd0, 0, 32'sh0001_0000, 1, 1);
        load_entry(3, 2, 1);
        send_command(MODE_PROJ, 2'd0, 2'd0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
        send_command(MODE_ROTATE, 2'd0, 2'd0, 0, 32'sh8000_0000, 32'sh8000_0000, 0);
    endtask

    // Mostly transforms, mixed with matrix reloads, post-translates and extreme noise.
    task automatic test_random_stream(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 4) begin
                load_entry($urandom_range(0, 3), $urandom_range(0, 3),
                           ($urandom_range(0, 2) == 0) ? rand_word() :
                           $signed(32'($urandom_range(0, 1 << 18))) - (1 <<< 17));
            end else if (pick == 4) begin
                send_command(MODE_POST_TRANS, 2'($urandom), 2'($urandom), $urandom,
                             rand_coord(), rand_coord(), rand_coord());
            end else if (pick == 5) begin
                send_command(3'($urandom), 2'($urandom), 2'($urandom), $urandom,
                             rand_word(), rand_word(), rand_word());
            end else begin
                send_command(3'($urandom_range(MODE_AFFINE, MODE_PROJ)), 2'($urandom),
                             2'($urandom), $urandom, rand_coord(), rand_coord(),
                             rand_coord());
            end
        end
    endtask

    initial begin
        error_count   = 0;
        items_sent    = 0;
        results_seen  = 0;
        cycle_count   = 0;
        for (int k = 0; k < 16; k++)
            mat_copy[k] = (k % 5 == 0) ? (32'sd1 <<< FB) : 32'sd0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_mode        <= MODE_LOAD;
        i_row         <= '0;
        i_col         <= '0;
        i_entry_value <= '0;
        i_vec_x       <= '0;
        i_vec_y       <= '0;
        i_vec_z       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_modes();
        test_random_stream(2000);
        i_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (150) @(posedge i_clk);
        $display("Sent %0d commands over all seven modes and the unused code;", items_sent);
        $display("checked %0d results in %0d cycles.", results_seen, cycle_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
